>>> hw/rtl/huffman_code_bit_packer_macros.svh
// Assertion helpers for the bit packer; clock clk, reset rst_n.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Same-cycle implication.
`define HCBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int NUM_SYMBOLS  = 128;
  localparam int MAX_CODE_LEN = 31;
  localparam int BYTE_W       = 8;
  localparam int SYM_W        = 7;
  localparam int WORD_W       = 31;
  localparam int LEN_W        = 5;
  localparam int PEND_W       = 7;
  localparam int PCNT_W       = 3;
  localparam int ACC_W        = PEND_W + WORD_W;
  localparam int CNT_W        = 6;
  localparam int ENTRY_W      = LEN_W + WORD_W;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;
  localparam logic [SYM_W-1:0] SYM_END = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ALIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic merge;
    logic align;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic out_free;
    logic cnt_ge8;
    logic cnt_nz;
    logic eom;
    logic last_byte;
  } sts_t;

endpackage

>>> hw/rtl/hcbp_ifs.sv
interface hcbp_in_if;
  import hcbp_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SYM_W-1:0]    symbol;
  logic [WORD_W-1:0]   code_word;
  logic [LEN_W-1:0]    code_length;
  modport source (output valid, mode, symbol, code_word, code_length, input ready);
  modport sink   (input valid, mode, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;
  logic              end_of_stream;
  modport source (output valid, packed_byte, last_of_run, end_of_stream, input ready);
  modport sink   (input valid, packed_byte, last_of_run, end_of_stream, output ready);
endinterface

>>> hw/rtl/huffman_code_bit_packer.sv
// Load transaction: the block is ready again in the next cycle.
// Encode transaction: lookup, merge and align, then one byte per cycle into the output
// register (0 to 5 bytes) while it is free.
// The input is held off until the encode finishes.
// Reset (synchronous, rst_n low) clears the table valid bits, the pending bits, the
// output valid and the controller; no clearing pass.
module huffman_code_bit_packer (
  input logic        clk,
  input logic        rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);
  import hcbp_pkg::*;
  `include "huffman_code_bit_packer_macros.svh"

  cmd_t cmd;
  sts_t sts;

  hcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcbp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_ch.mode),
    .in_symbol         (in_ch.symbol),
    .in_code_word      (in_ch.code_word),
    .in_code_length    (in_ch.code_length),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_packed_byte   (out_ch.packed_byte),
    .out_last_of_run   (out_ch.last_of_run),
    .out_end_of_stream (out_ch.end_of_stream)
  );

  `HCBP_ASSERT_NOW(a_eos_is_last, out_ch.valid && out_ch.end_of_stream, out_ch.last_of_run, "end of stream without last of run")
  `HCBP_ASSERT_NEXT(a_encode_busy, in_ch.valid && in_ch.ready && in_ch.mode == MODE_ENCODE, !in_ch.ready, "encode transaction did not hold off input")
  `HCBP_ASSERT_NEXT(a_load_quick, in_ch.valid && in_ch.ready && in_ch.mode == MODE_LOAD, in_ch.ready, "load transaction stalled input")
  `HCBP_ASSERT_NOW(a_emit_slot, cmd.emit, !out_ch.valid || out_ch.ready, "byte emitted over a waiting result")

endmodule

>>> hw/rtl/hcbp_dp.sv
module hcbp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcbp_pkg::cmd_t              cmd,
  output hcbp_pkg::sts_t              sts,
  input  logic                        in_mode,
  input  logic [hcbp_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcbp_pkg::WORD_W-1:0] in_code_word,
  input  logic [hcbp_pkg::LEN_W-1:0]  in_code_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0] out_packed_byte,
  output logic                        out_last_of_run,
  output logic                        out_end_of_stream
);
  import hcbp_pkg::*;

  logic [ENTRY_W-1:0]     mem_r [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_r;
  logic [ENTRY_W-1:0]     rd_data_r;
  logic                   rd_vld_r;
  logic                   eom_r;
  logic [ACC_W-1:0]       acc_r, acc_nxt, acc_aft;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_aft;
  logic [PEND_W-1:0]      pend_r;
  logic [PCNT_W-1:0]      pcnt_r;
  logic                   out_valid_r;
  logic [BYTE_W-1:0]      byte_r;
  logic                   last_r, eos_r;
  logic [LEN_W-1:0]       rd_len, ld_len;
  logic [WORD_W-1:0]      rd_word, ld_mask;
  logic [CNT_W-1:0]       shamt;

  // Clip length to the widest code and drop bits above it.
  always_comb begin
    if (32'(in_code_length) > MAX_CODE_LEN) begin
      ld_len = LEN_W'(MAX_CODE_LEN);
    end else begin
      ld_len = in_code_length;
    end
    ld_mask = ~({WORD_W{1'b1}} << ld_len);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_r[in_symbol] <= {ld_len, in_code_word & ld_mask};
    end
    if (cmd.lookup) begin
      rd_data_r <= mem_r[in_symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.load) begin
      vld_r[in_symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_vld_r <= vld_r[in_symbol];
      eom_r    <= (in_symbol == SYM_END);
    end
  end

  // Unloaded entries read as an empty code.
  assign rd_len  = rd_vld_r ? rd_data_r[ENTRY_W-1 -: LEN_W] : '0;
  assign rd_word = rd_vld_r ? rd_data_r[WORD_W-1:0] : '0;
  assign shamt   = CNT_W'(ACC_W) - cnt_r;

  // Accumulator after a possible byte emission this cycle.
  always_comb begin
    acc_aft = acc_r;
    cnt_aft = cnt_r;
    if (cmd.emit) begin
      if (sts.cnt_ge8) begin
        acc_aft = acc_r << BYTE_W;
        cnt_aft = cnt_r - CNT_W'(BYTE_W);
      end else begin
        acc_aft = '0;
        cnt_aft = '0;
      end
    end
  end

  always_comb begin
    acc_nxt = acc_aft;
    cnt_nxt = cnt_aft;
    if (cmd.merge) begin
      acc_nxt = ({{WORD_W{1'b0}}, pend_r} << rd_len) | {{PEND_W{1'b0}}, rd_word};
      cnt_nxt = CNT_W'(pcnt_r) + CNT_W'(rd_len);
    end else if (cmd.align) begin
      // left-justify the valid bits
      acc_nxt = acc_r << shamt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end else if (cmd.finish) begin
      if (eom_r) begin
        pend_r <= '0;
        pcnt_r <= '0;
      end else begin
        pend_r <= acc_aft[ACC_W-1 -: PEND_W] >> (PCNT_W'(PEND_W) - cnt_aft[PCNT_W-1:0]);
        pcnt_r <= cnt_aft[PCNT_W-1:0];
      end
    end
  end

  always_comb begin
    sts.mode     = in_mode;
    sts.out_free = !out_valid_r || out_ready;
    sts.cnt_ge8  = (cnt_r >= CNT_W'(BYTE_W));
    sts.cnt_nz   = (cnt_r != '0);
    sts.eom      = eom_r;
    if (sts.cnt_ge8) begin
      sts.last_byte = eom_r ? (cnt_r == CNT_W'(BYTE_W)) : (cnt_r < CNT_W'(2 * BYTE_W));
    end else begin
      sts.last_byte = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_r <= acc_r[ACC_W-1 -: BYTE_W];
      last_r <= sts.last_byte;
      eos_r  <= sts.last_byte && eom_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packed_byte   = byte_r;
  assign out_last_of_run   = last_r;
  assign out_end_of_stream = eos_r;

endmodule

>>> hw/rtl/hcbp_ctrl.sv
module hcbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hcbp_pkg::sts_t sts,
  output hcbp_pkg::cmd_t cmd
);
  import hcbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.mode == MODE_ENCODE) begin
            cmd.lookup = 1'b1;
            state_nxt  = ST_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.merge = 1'b1;
        state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          if (sts.cnt_ge8 || (sts.eom && sts.cnt_nz)) begin
            cmd.emit = 1'b1;
            if (sts.last_byte) begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end else begin
            // no byte for this transaction
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sim/tb_huffman_code_bit_packer.sv
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_run;
    logic              end_of_stream;
  } packed_byte_t;

  logic clk;
  logic rst_n;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Code table and bit accumulator as the block should hold them.
  logic [WORD_W-1:0] code_bits [NUM_SYMBOLS];
  int unsigned       code_len [NUM_SYMBOLS];
  logic [63:0]       carry_bits;
  int unsigned       carry_count;

  packed_byte_t expected_bytes[$];
  int           error_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           stall_request;
  int           stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("tb_huffman_code_bit_packer failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < 40)
      $display("%0t: mismatch %s: got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void predict_item(input logic mode, input logic [SYM_W-1:0] sym,
                                       input logic [WORD_W-1:0] word,
                                       input logic [LEN_W-1:0] len);
    logic [63:0]  acc;
    int unsigned  cnt;
    int unsigned  clen;
    packed_byte_t run_q[$];
    packed_byte_t r;
    if (mode == MODE_LOAD) begin
      clen = 32'(len);
      if (clen > MAX_CODE_LEN) clen = MAX_CODE_LEN;
      if (sym < NUM_SYMBOLS) begin
        code_bits[sym] = WORD_W'(64'(word) & ((64'd1 << clen) - 64'd1));
        code_len[sym]  = clen;
      end
      return;
    end
    acc = carry_bits;
    cnt = carry_count;
    if (sym < NUM_SYMBOLS && code_len[sym] > 0) begin
      acc = (acc << code_len[sym]) | 64'(code_bits[sym]);
      cnt = cnt + code_len[sym];
    end
    while (cnt >= 8) begin
      r = '0;
      r.data_byte = BYTE_W'(acc >> (cnt - 8));
      run_q.push_back(r);
      cnt = cnt - 8;
      acc = acc & ((64'd1 << cnt) - 64'd1);
    end
    if (sym == SYM_END) begin
      // pad the partial byte with zeros and flag the stream end
      if (cnt > 0) begin
        r = '0;
        r.data_byte = BYTE_W'(acc << (8 - cnt));
        run_q.push_back(r);
      end
      acc = '0;
      cnt = 0;
      if (run_q.size() > 0) run_q[run_q.size()-1].end_of_stream = 1'b1;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) expected_bytes.push_back(run_q[i]);
    carry_bits  = acc;
    carry_count = cnt;
  endfunction

  // Offer one item, hold it until the transaction, then predict its bytes.
  task automatic send_item(input logic mode, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.symbol      <= sym;
    in_ch.code_word   <= word;
    in_ch.code_length <= len;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(mode, sym, word, len);
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_ch.packed_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.packed_byte !== want.data_byte)
          report_mismatch("packed_byte", out_ch.packed_byte, want.data_byte);
        if (out_ch.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_ch.last_of_run, want.last_of_run);
        if (out_ch.end_of_stream !== want.end_of_stream)
          report_mismatch("end_of_stream", out_ch.end_of_stream, want.end_of_stream);
      end
    end
  end

  task automatic test_directed();
    // empty codes at reset: nothing comes out, not even for the end marker
    send_item(MODE_ENCODE, 7'd5, 31'h7FFF_FFFF, 5'd31);
    send_item(MODE_ENCODE, SYM_END, 31'h0, 5'd0);
    // upper word bits masked off; longest codes with all ones and all zeros
    send_item(MODE_LOAD, 7'd1, 31'h7FFF_FFFF, 5'd3);
    send_item(MODE_LOAD, 7'd2, 31'h7FFF_FFFF, 5'd31);
    send_item(MODE_LOAD, 7'd127, 31'h0, 5'd31);
    send_item(MODE_LOAD, 7'd3, 31'h5A, 5'd8);
    send_item(MODE_LOAD, 7'd4, 31'h1, 5'd1);
    send_item(MODE_LOAD, SYM_END, 31'h7FFF_FFFE, 5'd2);
    send_item(MODE_ENCODE, 7'd3, 31'h0, 5'd0);
    send_item(MODE_ENCODE, 7'd1, 31'h0, 5'd0);
    send_item(MODE_ENCODE, 7'd2, 31'h0, 5'd0);
    send_item(MODE_ENCODE, 7'd100, 31'h0, 5'd0);
    send_item(MODE_ENCODE, 7'd127, 31'h0, 5'd0);
    send_item(MODE_ENCODE, SYM_END, 31'h0, 5'd0);
    // end marker on a byte boundary: no pad byte
    send_item(MODE_LOAD, SYM_END, 31'hC3, 5'd8);
    send_item(MODE_ENCODE, SYM_END, 31'h0, 5'd0);
    // empty end marker code flushes a single pending bit
    send_item(MODE_LOAD, SYM_END, 31'h7FFF_FFFF, 5'd0);
    send_item(MODE_ENCODE, 7'd4, 31'h0, 5'd0);
    send_item(MODE_ENCODE, SYM_END, 31'h0, 5'd0);
    // seven pending bits plus a 31-bit end marker: four bytes and a pad byte
    send_item(MODE_LOAD, 7'd5, 31'h7F, 5'd7);
    send_item(MODE_LOAD, SYM_END, 31'h7FFF_FFFF, 5'd31);
    send_item(MODE_ENCODE, 7'd5, 31'h0, 5'd0);
    send_item(MODE_ENCODE, SYM_END, 31'h0, 5'd0);
    // clear an entry with a zero length
    send_item(MODE_LOAD, 7'd3, 31'h7FFF_FFFF, 5'd0);
    send_item(MODE_ENCODE, 7'd3, 31'h0, 5'd0);
    wait_for_drain();
  endtask

  // Table refreshes followed by encoded runs, most closed by the end marker.
  task automatic test_random_stream(input int n_items);
    int sent;
    int n_loads;
    int run_len;
    logic [SYM_W-1:0] sym;
    sent = 0;
    while (sent < n_items) begin
      n_loads = $urandom_range(4);
      repeat (n_loads) begin
        sym = ($urandom_range(3) == 0) ? SYM_W'($urandom_range(127)) : SYM_W'($urandom_range(15));
        send_item(MODE_LOAD, sym, WORD_W'($urandom()), LEN_W'($urandom_range(31)));
        sent++;
      end
      run_len = $urandom_range(8, 1);
      repeat (run_len) begin
        sym = ($urandom_range(5) == 0) ? SYM_W'($urandom_range(127))
                                       : SYM_W'($urandom_range(15, 1));
        send_item(MODE_ENCODE, sym, WORD_W'($urandom()), LEN_W'($urandom_range(31)));
        sent++;
      end
      if ($urandom_range(3) != 0) begin
        send_item(MODE_ENCODE, SYM_END, WORD_W'($urandom()), LEN_W'($urandom_range(31)));
        sent++;
      end
    end
  endtask

  // Hold the receiver off while long codes keep coming, so the input stalls.
  task automatic test_output_backpressure();
    send_item(MODE_LOAD, 7'd10, WORD_W'($urandom()), 5'd31);
    send_item(MODE_LOAD, 7'd11, WORD_W'($urandom()), 5'd29);
    stall_request = 300;
    for (int i = 0; i < 16; i++)
      send_item(MODE_ENCODE, (i % 2 == 0) ? 7'd10 : 7'd11, WORD_W'($urandom()), 5'd0);
    send_item(MODE_ENCODE, SYM_END, WORD_W'($urandom()), 5'd0);
    wait_for_drain();
  endtask

  initial begin
    error_count   = 0;
    stall_request = 0;
    stall_left    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (code_len[i]) begin
      code_len[i]  = 0;
      code_bits[i] = '0;
    end
    carry_bits  = '0;
    carry_count = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD;
    in_ch.symbol      <= '0;
    in_ch.code_word   <= '0;
    in_ch.code_length <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();

    send_idle_pct = 7;
    recv_idle_pct = 80;
    test_random_stream(35);
    wait_for_drain();

    send_idle_pct = 80;
    recv_idle_pct = 7;
    test_random_stream(35);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(35);
    test_output_backpressure();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never received", 0, expected_bytes.size());
    if (error_count == 0) begin
      $display("tb_huffman_code_bit_packer passed");
    end else begin
      $display("tb_huffman_code_bit_packer failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_ifs.sv
hw/rtl/hcbp_dp.sv
hw/rtl/hcbp_ctrl.sv
hw/rtl/huffman_code_bit_packer.sv
sim/tb_huffman_code_bit_packer.sv
